>>> rtl/mrp_pkg.sv
// Shared types, constants and the witness table for the Miller-Rabin prime tester.
// No dependencies; every other file of the block but mrp_checker imports this package.
`timescale 1ns / 1ps

package mrp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int CAND_W     = 32;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int NUM_WIT    = 3;
  localparam int WIT_IDX_W  = $clog2(NUM_WIT);

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [WIT_IDX_W-1:0]  wit_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DSTEP,
    OP_WNEXT,
    OP_BASE_INIT,
    OP_MUL_X,
    OP_SQ_BASE,
    OP_ESHIFT,
    OP_IINIT,
    OP_SQ_X
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic n_even;
    logic n_eq2;
    logic d_lsb;
    logic e_zero;
    logic e_lsb;
    logic e_one;
    logic x_one;
    logic x_nm1;
    logic i_lt_r;
    logic w_eq_n;
    logic w_last;
    logic mul_done;
  } dp_stat_t;

  function automatic val_t witness(input wit_idx_t idx);
    val_t w;
    case (idx)
      WIT_IDX_W'(0): w = VALUE_BITS'(2);
      WIT_IDX_W'(1): w = VALUE_BITS'(7);
      default:       w = VALUE_BITS'(61);
    endcase
    return w;
  endfunction

endpackage

>>> rtl/mrp_if.sv
// Valid/ready channel interfaces for candidate requests and prime results.
// Depends on mrp_pkg for the candidate width.
`timescale 1ns / 1ps

interface mrp_cand_if import mrp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CAND_W-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface mrp_res_if ();
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

>>> rtl/mrp_modmul.sv
// Bit-serial interleaved modular multiplier: result = a * b mod n, one bit of b per cycle.
// Depends on mrp_pkg. Operand a must be below n; b may be any value.
`timescale 1ns / 1ps

module mrp_modmul import mrp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  val_t a,
  input  val_t b,
  input  val_t n,
  output logic done,
  output val_t result
);

  localparam int EW = VALUE_BITS + 2;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  val_t             a_r;
  val_t             b_r;
  val_t             n_r;
  val_t             acc_r;
  val_t             acc_nxt;

  logic [EW-1:0] t;
  logic [EW-1:0] n1;
  logic [EW-1:0] n2;
  logic [EW-1:0] red;

  always_comb begin
    n1 = {2'b00, n_r};
    n2 = {1'b0, n_r, 1'b0};
    t  = {1'b0, acc_r, 1'b0} + (b_r[VALUE_BITS-1] ? {2'b00, a_r} : {EW{1'b0}});
    if (t >= n2) begin
      red = t - n2;
    end else if (t >= n1) begin
      red = t - n1;
    end else begin
      red = t;
    end
    acc_nxt = red[VALUE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      n_r   <= n;
      acc_r <= '0;
      cnt_r <= CNT_W'(VALUE_BITS - 1);
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[VALUE_BITS-2:0], 1'b0};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

>>> rtl/mrp_datapath.sv
// Datapath of the prime tester: candidate, exponent split, witness, power and loop registers.
// Depends on mrp_pkg and mrp_modmul; driven by commands from mrp_ctrl.
`timescale 1ns / 1ps

module mrp_datapath import mrp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CAND_W-1:0] candidate,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat
);

  typedef enum logic {DEST_BASE, DEST_X} dest_t;

  val_t             n_r;
  val_t             d_r;
  val_t             e_r;
  val_t             x_r;
  val_t             base_r;
  logic [CNT_W-1:0] r_r;
  logic [CNT_W-1:0] i_r;
  wit_idx_t         widx_r;
  dest_t            dest_r;

  val_t n_m1;
  val_t wit;
  logic mul_start;
  val_t mul_a;
  val_t mul_b;
  logic mul_done;
  val_t mul_res;

  assign n_m1 = n_r - VALUE_BITS'(1);
  assign wit  = witness(widx_r);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = x_r;
    mul_b     = base_r;
    case (cmd.op)
      OP_BASE_INIT: begin
        mul_start = 1'b1;
        mul_a     = VALUE_BITS'(1);
        mul_b     = wit;
      end
      OP_MUL_X: begin
        mul_start = 1'b1;
        mul_a     = x_r;
        mul_b     = base_r;
      end
      OP_SQ_BASE: begin
        mul_start = 1'b1;
        mul_a     = base_r;
        mul_b     = base_r;
      end
      OP_SQ_X: begin
        mul_start = 1'b1;
        mul_a     = x_r;
        mul_b     = x_r;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  mrp_modmul u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .n      (n_r),
    .done   (mul_done),
    .result (mul_res)
  );

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        n_r    <= candidate[VALUE_BITS-1:0];
        d_r    <= {candidate[VALUE_BITS-1:1], 1'b0};
        r_r    <= '0;
        widx_r <= '0;
      end
      OP_DSTEP: begin
        d_r <= {1'b0, d_r[VALUE_BITS-1:1]};
        r_r <= r_r + CNT_W'(1);
      end
      OP_WNEXT: begin
        widx_r <= widx_r + WIT_IDX_W'(1);
      end
      OP_BASE_INIT: begin
        x_r    <= VALUE_BITS'(1);
        e_r    <= d_r;
        dest_r <= DEST_BASE;
      end
      OP_MUL_X: begin
        dest_r <= DEST_X;
      end
      OP_SQ_BASE: begin
        e_r    <= {1'b0, e_r[VALUE_BITS-1:1]};
        dest_r <= DEST_BASE;
      end
      OP_ESHIFT: begin
        e_r <= {1'b0, e_r[VALUE_BITS-1:1]};
      end
      OP_IINIT: begin
        i_r <= CNT_W'(1);
      end
      OP_SQ_X: begin
        i_r    <= i_r + CNT_W'(1);
        dest_r <= DEST_X;
      end
      default: begin
      end
    endcase
    if (mul_done) begin
      if (dest_r == DEST_X) begin
        x_r <= mul_res;
      end else begin
        base_r <= mul_res;
      end
    end
  end

  always_comb begin
    stat.n_lt2    = (n_r < VALUE_BITS'(2));
    stat.n_even   = ~n_r[0];
    stat.n_eq2    = (n_r == VALUE_BITS'(2));
    stat.d_lsb    = d_r[0];
    stat.e_zero   = (e_r == '0);
    stat.e_lsb    = e_r[0];
    stat.e_one    = (e_r == VALUE_BITS'(1));
    stat.x_one    = (x_r == VALUE_BITS'(1));
    stat.x_nm1    = (x_r == n_m1);
    stat.i_lt_r   = (i_r < r_r);
    stat.w_eq_n   = (wit == n_r);
    stat.w_last   = (widx_r == WIT_IDX_W'(NUM_WIT - 1));
    stat.mul_done = mul_done;
  end

endmodule

>>> rtl/mrp_ctrl.sv
// Controller state machine that sequences classification, exponent split and witness rounds.
// Depends on mrp_pkg; issues commands to mrp_datapath and reads its status.
`timescale 1ns / 1ps

module mrp_ctrl import mrp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     out_free,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     in_ready,
  output logic     push,
  output logic     result
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_DSPLIT,
    S_RSTART,
    S_WBASE,
    S_PCHK,
    S_WMX,
    S_PSQ,
    S_WSQB,
    S_RCHK,
    S_LCHK,
    S_WSQX,
    S_SQCHK,
    S_PASS,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   res_r;
  logic   res_nxt;

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd.op    = OP_NONE;
    push      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        if (stat.n_lt2) begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if (stat.n_even) begin
          res_nxt   = stat.n_eq2;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DSPLIT;
        end
      end
      S_DSPLIT: begin
        if (!stat.d_lsb) begin
          cmd.op = OP_DSTEP;
        end else begin
          state_nxt = S_RSTART;
        end
      end
      S_RSTART: begin
        if (stat.w_eq_n) begin
          state_nxt = S_PASS;
        end else begin
          cmd.op    = OP_BASE_INIT;
          state_nxt = S_WBASE;
        end
      end
      S_WBASE: begin
        if (stat.mul_done) begin
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        if (stat.e_zero) begin
          state_nxt = S_RCHK;
        end else if (stat.e_lsb) begin
          cmd.op    = OP_MUL_X;
          state_nxt = S_WMX;
        end else begin
          state_nxt = S_PSQ;
        end
      end
      S_WMX: begin
        if (stat.mul_done) begin
          state_nxt = S_PSQ;
        end
      end
      S_PSQ: begin
        if (stat.e_one) begin
          cmd.op    = OP_ESHIFT;
          state_nxt = S_PCHK;
        end else begin
          cmd.op    = OP_SQ_BASE;
          state_nxt = S_WSQB;
        end
      end
      S_WSQB: begin
        if (stat.mul_done) begin
          state_nxt = S_PCHK;
        end
      end
      S_RCHK: begin
        if (stat.x_one || stat.x_nm1) begin
          state_nxt = S_PASS;
        end else begin
          cmd.op    = OP_IINIT;
          state_nxt = S_LCHK;
        end
      end
      S_LCHK: begin
        if (stat.i_lt_r) begin
          cmd.op    = OP_SQ_X;
          state_nxt = S_WSQX;
        end else begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_WSQX: begin
        if (stat.mul_done) begin
          state_nxt = S_SQCHK;
        end
      end
      S_SQCHK: begin
        if (stat.x_nm1) begin
          state_nxt = S_PASS;
        end else if (stat.x_one) begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LCHK;
        end
      end
      S_PASS: begin
        if (stat.w_last) begin
          res_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_WNEXT;
          state_nxt = S_RSTART;
        end
      end
      S_DONE: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign result   = res_r;

endmodule

>>> rtl/miller_rabin_prime_test32_core.sv
// Top level of the deterministic Miller-Rabin prime tester (witnesses 2, 7 and 61).
// Depends on mrp_pkg, mrp_if, mrp_ctrl and mrp_datapath.
//
//   channel   direction  payload          request accepted when
//   in_chan   sink       candidate[31:0]  valid && ready
//   out_chan  source     is_prime         valid && ready
//
// Each modular multiplication holds the controller in a wait state until the bit-serial
// multiplier reports done. A candidate below 2 or even is classified without any
// multiplication; an odd one needs up to 62 multiplications per witness on that single
// shared multiplier.
// Reset is synchronous and active low; it clears the controller and the output valid flag.
// The result sits in an output register, so a new request is taken while it waits;
// a finished result waits in the controller if the output register is still full.
`timescale 1ns / 1ps

module miller_rabin_prime_test32_core import mrp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  mrp_cand_if.sink        in_chan,
  mrp_res_if.source       out_chan
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     push;
  logic     result;
  logic     out_free;
  logic     out_valid_r;
  logic     out_bit_r;

  assign out_free = ~out_valid_r | out_chan.ready;

  mrp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_ready),
    .push     (push),
    .result   (result)
  );

  mrp_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .candidate (in_chan.candidate),
    .cmd       (cmd),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_bit_r <= result;
    end
  end

  assign in_chan.ready     = in_ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.is_prime = out_bit_r;

endmodule

>>> rtl/mrp_checker.sv
// Port-level checker for the prime tester, bound to the top level.
// Depends on the top level's channel interfaces only.
`timescale 1ns / 1ps

module mrp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_is_prime
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_is_prime))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while a test is running");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared one cycle after a request");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result issued while the tester was idle");

endmodule

bind miller_rabin_prime_test32_core mrp_checker u_mrp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_is_prime (out_chan.is_prime)
);

>>> sim/tb.sv
// Testbench for miller_rabin_prime_test32_core: checks the prime verdict for each candidate.
// Uses mrp_pkg and the mrp_if channel interfaces. A local predictor queues the expected
// verdict for each accepted request, and a monitor compares it with each accepted result.
`timescale 1ns / 1ps

module tb;
  import mrp_pkg::*;

  localparam int NUM_RANDOM   = 900;
  localparam int IDLE_PCT     = 27;
  localparam int DRAIN_CYCLES = 200;
  localparam int QUIET_FIRST  = 300;
  localparam int QUIET_LAST   = 450;

  typedef struct packed {
    logic [CAND_W-1:0] cand;
    bit                is_prime;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic quiet;

  mrp_cand_if cand_bus ();
  mrp_res_if  res_bus ();

  logic [CAND_W-1:0] cand_queue[$];
  verdict_t          verdict_q[$];
  int                cands_taken;
  int                errors;
  bit                req_taken;

  miller_rabin_prime_test32_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (cand_bus),
    .out_chan (res_bus)
  );

  assign quiet = (cands_taken >= QUIET_FIRST) && (cands_taken < QUIET_LAST);

  function automatic longint unsigned modmul(longint unsigned a, longint unsigned b,
                                             longint unsigned m);
    return (a * b) % m;
  endfunction

  function automatic longint unsigned modexp(longint unsigned b, longint unsigned e,
                                             longint unsigned m);
    longint unsigned acc;
    acc = 64'd1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) begin
        acc = modmul(acc, b, m);
      end
      b = modmul(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic bit passes_witness(longint unsigned n, longint unsigned d, int r,
                                        longint unsigned a);
    longint unsigned x;
    if (a == n) begin
      return 1'b1;
    end
    x = modexp(a, d, n);
    if (x == 1 || x == n - 1) begin
      return 1'b1;
    end
    for (int i = 1; i < r; i++) begin
      x = modmul(x, x, n);
      if (x == n - 1) begin
        return 1'b1;
      end
      if (x == 1) begin
        return 1'b0;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit prime_check(logic [CAND_W-1:0] cand);
    longint unsigned n;
    longint unsigned d;
    longint unsigned a;
    int              r;
    n = 64'(cand) & ((64'd1 << VALUE_BITS) - 64'd1);
    if (n < 2) begin
      return 1'b0;
    end
    if (!n[0]) begin
      return n == 2;
    end
    d = n - 1;
    r = 0;
    while (!d[0]) begin
      d = d >> 1;
      r++;
    end
    for (int k = 0; k < 3; k++) begin
      a = (k == 0) ? 64'd2 : ((k == 1) ? 64'd7 : 64'd61);
      if (!passes_witness(n, d, r, a)) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(64'd1_000_000_000);
    $display("tb: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && cand_bus.valid && cand_bus.ready) begin
      verdict_q.push_back('{cand: cand_bus.candidate,
                            is_prime: prime_check(cand_bus.candidate)});
      cands_taken++;
      req_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      cand_bus.valid <= 1'b0;
    end else if (!cand_bus.valid || req_taken) begin
      if (cand_queue.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        cand_bus.valid     <= 1'b1;
        cand_bus.candidate <= cand_queue.pop_front();
      end else begin
        cand_bus.valid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (verdict_q.size() == 0) begin
        if (errors < 10) begin
          $display("tb: result is_prime=%0b with no request outstanding", res_bus.is_prime);
        end
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (res_bus.is_prime !== want.is_prime) begin
          if (errors < 10) begin
            $display("tb: candidate %0d expected is_prime=%0b, got %0b",
                     want.cand, want.is_prime, res_bus.is_prime);
          end
          errors++;
        end
      end
    end
  end

  initial begin
    logic [CAND_W-1:0] c;
    logic [15:0]       p;
    logic [15:0]       q;
    int                kind;

    rst_n              = 1'b0;
    cand_bus.valid     = 1'b0;
    cand_bus.candidate = '0;
    res_bus.ready      = 1'b0;
    cands_taken        = 0;
    errors             = 0;
    req_taken          = 1'b0;

    // Trivial values, the witnesses themselves, small odd composites, strong
    // pseudoprimes to several bases and values at the top of the range.
    cand_queue = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd49,
                   32'd61, 32'd63, 32'd67, 32'd121, 32'd561, 32'd2047, 32'd3721,
                   32'd25326001, 32'd3215031751, 32'd2147483647, 32'd4294967291,
                   32'd4294967295, 32'd4294967294, 32'h8000_0000, 32'h5555_5555,
                   32'hAAAA_AAAB};

    for (int i = 0; i < NUM_RANDOM; i++) begin
      kind = $urandom_range(99);
      p = 16'($urandom());
      q = 16'($urandom());
      if (kind < 25) begin
        c = $urandom() | 32'd1;
        while (!prime_check(c)) begin
          c = c + 32'd2;
        end
      end else if (kind < 50) begin
        c = $urandom() | 32'd1;
      end else if (kind < 62) begin
        c = $urandom();
      end else if (kind < 74) begin
        c = $urandom_range(300);
      end else if (kind < 84) begin
        c = 32'(p | 16'd1) * 32'(q | 16'd1);
      end else if (kind < 92) begin
        c = 32'(p | 16'd1) * 32'(p | 16'd1);
      end else begin
        c = 32'hFFFF_FF00 | 32'(p[7:0]);
      end
      cand_queue.push_back(c);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cand_queue.size() != 0 || cand_bus.valid) begin
      @(posedge clk);
    end
    while (verdict_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && verdict_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
